// File: rtl/srd_pkg.sv
package srd_pkg;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [6:0] {
    PH_CTRL      = 7'b0000001,
    PH_REP_COUNT = 7'b0000010,
    PH_FF_COUNT  = 7'b0000100,
    PH_RUN_VALUE = 7'b0001000,
    PH_LITERAL   = 7'b0010000,
    PH_DRAIN_RUN = 7'b0100000,
    PH_DRAIN_REP = 7'b1000000
  } phase_t;

  // What produces the output byte of one word
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_DIRECT = 2'd1,
    KIND_HIST   = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_val;
    logic       hist_ok;
    logic       busy;
    logic       refused;
  } issue_t;

  localparam int          CFG_W       = 13;
  localparam int          OUT_TDATA_W = 16;
  localparam logic [7:0]  BYTE_ZERO   = 8'h00;
  localparam logic [7:0]  BYTE_LIT_MAX = 8'h7f;
  localparam logic [7:0]  BYTE_FF_RUN = 8'h80;
  localparam logic [7:0]  BYTE_ONES   = 8'hff;

endpackage

// File: rtl/srd_ram.sv
module srd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/srd_ctrl.sv
module srd_ctrl #(
  parameter int MAX_ROW_SPAN = 4096,
  localparam int AW  = (MAX_ROW_SPAN > 1) ? $clog2(MAX_ROW_SPAN) : 1,
  localparam int SPW = $clog2(MAX_ROW_SPAN + 1),
  localparam int SW  = (SPW > srd_pkg::CFG_W) ? SPW : srd_pkg::CFG_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [1:0]                 opcode,
  input  logic [7:0]                 data_byte,
  input  logic                       cfg_we,
  input  logic [srd_pkg::CFG_W-1:0]  cfg_wdata,
  output srd_pkg::issue_t            issue,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  output logic [AW-1:0]              wr_addr
);

  localparam logic [AW-1:0]  WP_LAST = AW'(MAX_ROW_SPAN - 1);
  localparam logic [SPW-1:0] FILL_MAX = SPW'(MAX_ROW_SPAN);
  localparam logic [SW:0]    DEPTH_X = (SW+1)'(MAX_ROW_SPAN);

  logic [srd_pkg::CFG_W-1:0] row_span_r;
  srd_pkg::phase_t           phase_r, phase_nxt;
  logic [6:0]                literal_left_r, literal_left_nxt;
  logic [7:0]                run_left_r, run_left_nxt;
  logic [7:0]                run_value_r, run_value_nxt;
  logic [7:0]                lines_left_r, lines_left_nxt;
  logic [SPW-1:0]            line_offset_r, line_offset_nxt;
  logic [AW-1:0]             wp_r, wp_nxt;
  logic [SPW-1:0]            fill_r, fill_nxt;

  logic [SW-1:0] eff_span;
  logic [SW:0]   src_w;
  logic [SW:0]   offset_inc;
  logic          push;
  logic          draining;

  always_comb begin
    eff_span = (SW'(row_span_r) > SW'(MAX_ROW_SPAN)) ? SW'(MAX_ROW_SPAN) : SW'(row_span_r);
    src_w = (SW+1)'(wp_r) + DEPTH_X - (SW+1)'(eff_span);
    if (src_w >= DEPTH_X) begin
      src_w = src_w - DEPTH_X;
    end
    offset_inc = (SW+1)'(line_offset_r) + (SW+1)'(1);
  end

  assign draining = (phase_r == srd_pkg::PH_DRAIN_RUN) || (phase_r == srd_pkg::PH_DRAIN_REP);

  always_comb begin
    phase_nxt        = phase_r;
    literal_left_nxt = literal_left_r;
    run_left_nxt     = run_left_r;
    run_value_nxt    = run_value_r;
    lines_left_nxt   = lines_left_r;
    line_offset_nxt  = line_offset_r;
    wp_nxt           = wp_r;
    fill_nxt         = fill_r;
    push             = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = AW'(src_w);
    wr_addr          = wp_r;
    issue            = '0;
    issue.kind       = srd_pkg::KIND_NONE;

    case (srd_pkg::opcode_t'(opcode))
      srd_pkg::OP_START: begin
        phase_nxt        = srd_pkg::PH_CTRL;
        literal_left_nxt = '0;
        run_left_nxt     = '0;
        run_value_nxt    = '0;
        lines_left_nxt   = '0;
        line_offset_nxt  = '0;
        wp_nxt           = '0;
        fill_nxt         = '0;
      end
      srd_pkg::OP_DATA: begin
        if (draining) begin
          issue.refused = 1'b1;
        end else begin
          case (phase_r)
            srd_pkg::PH_CTRL: begin
              if (data_byte == srd_pkg::BYTE_ZERO) begin
                phase_nxt = srd_pkg::PH_REP_COUNT;
              end else if (data_byte <= srd_pkg::BYTE_LIT_MAX) begin
                literal_left_nxt = data_byte[6:0];
                phase_nxt        = srd_pkg::PH_LITERAL;
              end else if (data_byte == srd_pkg::BYTE_FF_RUN) begin
                phase_nxt = srd_pkg::PH_FF_COUNT;
              end else begin
                run_left_nxt = {1'b0, data_byte[6:0]};
                phase_nxt    = srd_pkg::PH_RUN_VALUE;
              end
            end
            srd_pkg::PH_REP_COUNT: begin
              line_offset_nxt = '0;
              if (data_byte == srd_pkg::BYTE_ZERO || eff_span == '0) begin
                lines_left_nxt = '0;
                phase_nxt      = srd_pkg::PH_CTRL;
              end else begin
                lines_left_nxt = data_byte;
                phase_nxt      = srd_pkg::PH_DRAIN_REP;
              end
            end
            srd_pkg::PH_FF_COUNT: begin
              run_value_nxt = srd_pkg::BYTE_ONES;
              run_left_nxt  = data_byte;
              phase_nxt     = (data_byte == srd_pkg::BYTE_ZERO) ? srd_pkg::PH_CTRL
                                                                : srd_pkg::PH_DRAIN_RUN;
            end
            srd_pkg::PH_RUN_VALUE: begin
              run_value_nxt = data_byte;
              phase_nxt     = (run_left_r == '0) ? srd_pkg::PH_CTRL : srd_pkg::PH_DRAIN_RUN;
            end
            srd_pkg::PH_LITERAL: begin
              issue.kind     = srd_pkg::KIND_DIRECT;
              issue.byte_val = data_byte;
              push           = 1'b1;
              if (literal_left_r <= 7'd1) begin
                literal_left_nxt = '0;
                phase_nxt        = srd_pkg::PH_CTRL;
              end else begin
                literal_left_nxt = literal_left_r - 7'd1;
              end
            end
            default: begin
              phase_nxt = srd_pkg::PH_CTRL;
            end
          endcase
        end
      end
      srd_pkg::OP_TICK: begin
        if (phase_r == srd_pkg::PH_DRAIN_RUN) begin
          issue.kind     = srd_pkg::KIND_DIRECT;
          issue.byte_val = run_value_r;
          push           = 1'b1;
          if (run_left_r <= 8'd1) begin
            run_left_nxt = '0;
            phase_nxt    = srd_pkg::PH_CTRL;
          end else begin
            run_left_nxt = run_left_r - 8'd1;
          end
        end else if (phase_r == srd_pkg::PH_DRAIN_REP) begin
          // read one row back; entries not written since start read as zero
          issue.kind    = srd_pkg::KIND_HIST;
          issue.hist_ok = SW'(fill_r) >= eff_span;
          rd_en         = 1'b1;
          push          = 1'b1;
          if (offset_inc >= (SW+1)'(eff_span)) begin
            line_offset_nxt = '0;
            if (lines_left_r <= 8'd1) begin
              lines_left_nxt = '0;
              phase_nxt      = srd_pkg::PH_CTRL;
            end else begin
              lines_left_nxt = lines_left_r - 8'd1;
            end
          end else begin
            line_offset_nxt = SPW'(offset_inc);
          end
        end
      end
      default: ;
    endcase

    if (push) begin
      wp_nxt   = (wp_r == WP_LAST) ? '0 : wp_r + AW'(1);
      fill_nxt = (fill_r == FILL_MAX) ? fill_r : fill_r + SPW'(1);
    end

    issue.busy = (phase_nxt == srd_pkg::PH_DRAIN_RUN) || (phase_nxt == srd_pkg::PH_DRAIN_REP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_span_r     <= srd_pkg::CFG_W'(1);
      phase_r        <= srd_pkg::PH_CTRL;
      literal_left_r <= '0;
      run_left_r     <= '0;
      run_value_r    <= '0;
      lines_left_r   <= '0;
      line_offset_r  <= '0;
      wp_r           <= '0;
      fill_r         <= '0;
    end else begin
      if (cfg_we) begin
        row_span_r <= cfg_wdata;
      end
      if (accept) begin
        phase_r        <= phase_nxt;
        literal_left_r <= literal_left_nxt;
        run_left_r     <= run_left_nxt;
        run_value_r    <= run_value_nxt;
        lines_left_r   <= lines_left_nxt;
        line_offset_r  <= line_offset_nxt;
        wp_r           <= wp_nxt;
        fill_r         <= fill_nxt;
      end
    end
  end

  a_rep_has_lines: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == srd_pkg::PH_DRAIN_REP |-> lines_left_r != '0)
    else $error("repeat drain with no lines left");

  a_run_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == srd_pkg::PH_DRAIN_RUN |-> run_left_r != '0)
    else $error("run drain with no bytes left");

  a_wp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (SPW+1)'(wp_r) < (SPW+1)'(MAX_ROW_SPAN) && fill_r <= FILL_MAX)
    else $error("write pointer or fill count out of range");

endmodule

// File: rtl/srd_stage.sv
module srd_stage #(
  parameter int MAX_ROW_SPAN = 4096,
  localparam int AW = (MAX_ROW_SPAN > 1) ? $clog2(MAX_ROW_SPAN) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  srd_pkg::issue_t                issue,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [7:0]                     ram_rdata,
  output logic                           ram_we,
  output logic [AW-1:0]                  ram_waddr,
  output logic [7:0]                     ram_wdata,
  output logic                           in_ready,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [srd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic            s1_v_r;
  srd_pkg::issue_t s1_issue_r;
  logic [AW-1:0]   s1_waddr_r;
  logic            fwd_r;
  logic [7:0]      fwd_data_r;
  logic            out_v_r;
  logic [srd_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic       s1_move;
  logic       s1_wr;
  logic [7:0] s1_byte;

  assign s1_move  = s1_v_r && (!out_v_r || out_tready);
  assign in_ready = !s1_v_r || s1_move;
  assign s1_wr    = s1_issue_r.kind != srd_pkg::KIND_NONE;

  always_comb begin
    case (s1_issue_r.kind)
      srd_pkg::KIND_DIRECT: s1_byte = s1_issue_r.byte_val;
      srd_pkg::KIND_HIST: begin
        if (!s1_issue_r.hist_ok) begin
          s1_byte = srd_pkg::BYTE_ZERO;
        end else begin
          s1_byte = fwd_r ? fwd_data_r : ram_rdata;
        end
      end
      default: s1_byte = srd_pkg::BYTE_ZERO;
    endcase
  end

  // commit the history write as the word leaves this stage
  assign ram_we    = s1_move && s1_wr;
  assign ram_waddr = s1_waddr_r;
  assign ram_wdata = s1_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
        // the read races the write going out this cycle: take the new byte
        fwd_r  <= rd_en && ram_we && (s1_waddr_r == rd_addr);
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
        fwd_r  <= 1'b0;
      end
      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_issue_r <= issue;
      s1_waddr_r <= wr_addr;
      fwd_data_r <= s1_byte;
    end
    if (s1_move) begin
      out_data_r <= {5'b0, s1_issue_r.refused, s1_issue_r.busy, s1_byte, s1_wr};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  a_fwd_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_v_r)
    else $error("forward flag set with empty stage");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_move |-> !accept)
    else $error("word accepted over a stalled stage");

  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_v_r)
    else $error("stage word lost on the way out");

endmodule

// File: rtl/scanline_rle_decoder.sv
// Run-length decoder for a compressed scanline byte stream. One word is taken
// per cycle unless the output stalls, compressed byte or drain tick alike, and
// each word yields exactly one result word via the stage register and the
// output register, which lets a new word in while a result waits. Throughput
// is set by the history ring read: a repeat reads the byte one row back from a
// synchronous RAM of MAX_ROW_SPAN bytes and writes the produced byte as its
// word leaves the stage, forwarding it when the next read hits that entry. A
// fill count stands in for clearing the ring on reset or start, so there is no
// clearing pass. row_span may be written only while the block is idle.
module scanline_rle_decoder #(
  parameter int MAX_ROW_SPAN = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] data_byte
  input  logic [1:0]                      in_tuser,   // [1:0] opcode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] out_valid, [8:1] out_byte, [9] busy_res, [10] refused, [15:11] zero
  output logic [srd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [srd_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int AW = (MAX_ROW_SPAN > 1) ? $clog2(MAX_ROW_SPAN) : 1;

  logic            accept;
  srd_pkg::issue_t issue;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_rdata;

  assign accept = in_tvalid && in_tready;

  srd_ctrl #(.MAX_ROW_SPAN(MAX_ROW_SPAN)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .opcode    (in_tuser),
    .data_byte (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .issue     (issue),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr)
  );

  srd_ram #(.WIDTH(8), .DEPTH(MAX_ROW_SPAN)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en && accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  srd_stage #(.MAX_ROW_SPAN(MAX_ROW_SPAN)) u_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .issue      (issue),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .ram_rdata  (ram_rdata),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .in_ready   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: dv/scanline_rle_decoder_test.sv
module scanline_rle_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_SPAN    = 4096;
  localparam int          SETTLE      = 4;
  localparam int          HOLD_CYCLES = 300;
  localparam int          DRAIN_LIMIT = 5000;
  localparam int unsigned LIMIT       = 2000000;

  typedef struct packed {
    logic       valid;
    logic [7:0] byte_val;
    logic       busy;
    logic       refused;
  } decoded_t;

  class rle_decode_board;
    logic [srd_pkg::CFG_W-1:0] row_span;
    srd_pkg::phase_t           phase;
    int unsigned               literal_left;
    int unsigned               run_left;
    int unsigned               lines_left;
    int unsigned               line_offset;
    int unsigned               wr_ptr;
    logic [7:0]                run_value;
    logic [7:0]                ring [MAX_SPAN];
    decoded_t                  decoded_q [$];
    int                        errors;

    function new();
      row_span = 13'd1;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      phase = srd_pkg::PH_CTRL;
      literal_left = 0;
      run_left = 0;
      run_value = '0;
      lines_left = 0;
      line_offset = 0;
      wr_ptr = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function void set_span(logic [srd_pkg::CFG_W-1:0] v);
      row_span = v;
    endfunction

    function int unsigned eff_span();
      return (32'(row_span) > MAX_SPAN) ? MAX_SPAN : 32'(row_span);
    endfunction

    function bit draining();
      return phase == srd_pkg::PH_DRAIN_RUN || phase == srd_pkg::PH_DRAIN_REP;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void flush();
      decoded_q.delete();
    endfunction

    // Write a produced byte into history and hand it back
    function logic [7:0] record_byte(logic [7:0] v);
      ring[wr_ptr] = v;
      wr_ptr = (wr_ptr + 1) % MAX_SPAN;
      return v;
    endfunction

    function void take_input(srd_pkg::opcode_t op, logic [7:0] b);
      decoded_t    r;
      int unsigned rs;
      int unsigned src;
      r = '0;
      rs = eff_span();
      case (op)
        srd_pkg::OP_START: wipe();
        srd_pkg::OP_DATA: begin
          if (draining()) begin
            r.refused = 1'b1;
          end else begin
            case (phase)
              srd_pkg::PH_CTRL: begin
                if (b == srd_pkg::BYTE_ZERO) begin
                  phase = srd_pkg::PH_REP_COUNT;
                end else if (b <= srd_pkg::BYTE_LIT_MAX) begin
                  literal_left = 32'(b);
                  phase = srd_pkg::PH_LITERAL;
                end else if (b == srd_pkg::BYTE_FF_RUN) begin
                  phase = srd_pkg::PH_FF_COUNT;
                end else begin
                  run_left = 32'(b[6:0]);
                  phase = srd_pkg::PH_RUN_VALUE;
                end
              end
              srd_pkg::PH_REP_COUNT: begin
                line_offset = 0;
                if (b == srd_pkg::BYTE_ZERO || rs == 0) begin
                  lines_left = 0;
                  phase = srd_pkg::PH_CTRL;
                end else begin
                  lines_left = 32'(b);
                  phase = srd_pkg::PH_DRAIN_REP;
                end
              end
              srd_pkg::PH_FF_COUNT: begin
                run_value = srd_pkg::BYTE_ONES;
                run_left = 32'(b);
                phase = (b == srd_pkg::BYTE_ZERO) ? srd_pkg::PH_CTRL : srd_pkg::PH_DRAIN_RUN;
              end
              srd_pkg::PH_RUN_VALUE: begin
                run_value = b;
                phase = (run_left == 0) ? srd_pkg::PH_CTRL : srd_pkg::PH_DRAIN_RUN;
              end
              srd_pkg::PH_LITERAL: begin
                r.valid = 1'b1;
                r.byte_val = record_byte(b);
                if (literal_left > 0) literal_left--;
                if (literal_left == 0) phase = srd_pkg::PH_CTRL;
              end
              default: phase = srd_pkg::PH_CTRL;
            endcase
          end
        end
        srd_pkg::OP_TICK: begin
          if (phase == srd_pkg::PH_DRAIN_RUN) begin
            r.valid = 1'b1;
            r.byte_val = record_byte(run_value);
            if (run_left > 0) run_left--;
            if (run_left == 0) phase = srd_pkg::PH_CTRL;
          end else if (phase == srd_pkg::PH_DRAIN_REP) begin
            // one row back; a full-ring span reads the entry about to be overwritten
            src = (wr_ptr + MAX_SPAN - rs) % MAX_SPAN;
            r.valid = 1'b1;
            r.byte_val = record_byte(ring[src]);
            line_offset++;
            if (line_offset >= rs) begin
              line_offset = 0;
              if (lines_left > 0) lines_left--;
              if (lines_left == 0) phase = srd_pkg::PH_CTRL;
            end
          end
        end
        default: ;
      endcase
      r.busy = draining();
      decoded_q.push_back(r);
    endfunction

    function void compare_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_output(logic [srd_pkg::OUT_TDATA_W-1:0] w);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %h", $time, w);
        errors++;
        return;
      end
      want = decoded_q.pop_front();
      compare_field("out_valid", 32'(want.valid), 32'(w[0]));
      compare_field("out_byte", 32'(want.byte_val), 32'(w[8:1]));
      compare_field("busy_res", 32'(want.busy), 32'(w[9]));
      compare_field("refused", 32'(want.refused), 32'(w[10]));
    endfunction
  endclass

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata   = '0;  // [7:0] data_byte
  logic [1:0]                      in_tuser   = '0;  // [1:0] opcode
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // [0] out_valid, [8:1] out_byte, [9] busy_res, [10] refused, [15:11] zero
  logic [srd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_we     = 1'b0;
  logic [srd_pkg::CFG_W-1:0]       cfg_wdata  = '0;
  logic                            hold_ask   = 1'b0;

  rle_decode_board sb;
  int              burst_left = 0;
  int              sent = 0;
  int unsigned     cycles = 0;

  scanline_rle_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("scanline_rle_decoder_test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tdata);
  end

  // Receiver: stall pattern in modes of random length, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int mode_left;
    bit held;
    mode = 0;
    mode_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 120);
        end
        mode_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  task automatic send_word(srd_pkg::opcode_t op, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    sb.take_input(op, b);
    if (op != srd_pkg::OP_NONE) sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(srd_pkg::OP_DATA, b);
  endtask

  // Drop valid and hold until every decoded word is back or DRAIN_LIMIT runs out
  task automatic go_quiet();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0) begin
      $display("%0t: result words missing, expected %0d actual 0", $time, sb.pending());
      sb.errors++;
      sb.flush();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_span(logic [srd_pkg::CFG_W-1:0] v);
    go_quiet();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_span(v);
    cfg_we <= 1'b0;
  endtask

  // Tick out a pending run or repeat, poking it now and then with a refused byte or start
  task automatic drain_ticks();
    int pick;
    while (sb.draining()) begin
      pick = $urandom_range(0, 255);
      if (pick < 8) send_byte(8'($urandom_range(0, 255)));
      else if (pick == 8) send_word(srd_pkg::OP_START, 8'($urandom_range(0, 255)));
      else send_word(srd_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_record();
    int          pick;
    int          n;
    int unsigned rs;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 8);
      send_byte(8'(n));
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 45) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
      send_byte(srd_pkg::BYTE_FF_RUN);
      send_byte(8'(n));
      drain_ticks();
    end else if (pick < 70) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
      send_byte(srd_pkg::BYTE_FF_RUN | 8'(n));
      send_byte(8'($urandom_range(0, 255)));
      drain_ticks();
    end else if (pick < 88) begin
      // keep repeats short when rows are long
      rs = sb.eff_span();
      if (rs == 0 || (rs == 1 && $urandom_range(0, 7) == 0)) n = $urandom_range(0, 255);
      else if (rs >= 32) n = ($urandom_range(0, 3) == 0) ? 1 : 0;
      else n = $urandom_range(0, 32 / rs);
      send_byte(srd_pkg::BYTE_ZERO);
      send_byte(8'(n));
      drain_ticks();
    end else begin
      case ($urandom_range(0, 3))
        0: send_word(srd_pkg::OP_NONE, 8'($urandom_range(0, 255)));
        1: send_word(srd_pkg::OP_TICK, 8'($urandom_range(0, 255)));
        2: send_word(srd_pkg::OP_START, 8'($urandom_range(0, 255)));
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic run_phase(logic [srd_pkg::CFG_W-1:0] span, int budget, bit squeeze);
    write_span(span);
    send_word(srd_pkg::OP_START, 8'($urandom_range(0, 255)));
    if (squeeze) hold_ask <= 1'b1;
    sent = 0;
    while (sent < budget) begin
      send_record();
      if ($urandom_range(0, 49) == 0) go_quiet();
    end
  endtask

  initial begin : stimulus
    logic [srd_pkg::CFG_W-1:0] mid_span;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_span(13'd1);

    send_word(srd_pkg::OP_START, 8'h00);
    // repeat straight after start reads the cleared ring
    send_byte(srd_pkg::BYTE_ZERO);
    send_byte(8'h02);
    send_word(srd_pkg::OP_TICK, 8'h00);
    send_word(srd_pkg::OP_TICK, 8'hff);
    send_word(srd_pkg::OP_TICK, 8'h00);
    send_byte(8'h01);
    send_byte(8'hff);
    send_byte(srd_pkg::BYTE_FF_RUN);
    send_byte(8'h00);
    send_byte(srd_pkg::BYTE_ZERO);
    send_byte(8'h00);
    send_byte(8'h81);
    send_byte(8'ha5);
    send_byte(8'h5a);
    send_word(srd_pkg::OP_TICK, 8'h00);
    send_word(srd_pkg::OP_NONE, 8'hff);
    send_byte(srd_pkg::BYTE_FF_RUN);
    send_byte(8'h02);
    send_word(srd_pkg::OP_TICK, 8'h00);
    send_word(srd_pkg::OP_START, 8'hff);
    send_word(srd_pkg::OP_TICK, 8'h00);
    send_byte(srd_pkg::BYTE_ZERO);
    send_byte(8'h01);
    send_word(srd_pkg::OP_TICK, 8'h00);

    mid_span = 13'($urandom_range(4, 40));
    run_phase(13'd3, 400, 1'b0);
    run_phase(13'd0, 200, 1'b0);
    run_phase(mid_span, 500, 1'b0);
    run_phase(13'd4096, 250, 1'b0);
    run_phase(13'd8191, 120, 1'b0);
    run_phase(13'd2, 400, 1'b1);
    go_quiet();

    if (sb.errors == 0) begin
      $display("scanline_rle_decoder_test passed");
    end else begin
      $display("scanline_rle_decoder_test failed");
    end
    $finish;
  end

endmodule
